// ----- hdl/srec_record_writer_defines.svh -----
// Assertion macros shared by the S-record writer modules.
`ifndef SREC_RECORD_WRITER_DEFINES_SVH
`define SREC_RECORD_WRITER_DEFINES_SVH

// Checked at every clock edge outside reset.
`define SREC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SREC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/srec_pkg.sv -----
// Types, constants and helpers of the S-record writer.
package srec_pkg;

  localparam int MAX_DATA_BYTES = 32;
  localparam int BUF_DEPTH      = MAX_DATA_BYTES;
  localparam int BUF_AW         = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FILL_W         = $clog2(MAX_DATA_BYTES + 1) + 1;

  localparam int CMD_W   = 3;
  localparam int ADDR_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int CHAR_W  = 7;
  localparam int CCNT_W  = 2;
  localparam int CFG_W   = 32;
  localparam int CFG_IW  = 1;

  localparam logic [CFG_IW-1:0] REG_START_ADDR  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_HEADER_TEXT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN   = 3'd0,
    CMD_SECTION = 3'd1,
    CMD_DATA    = 3'd2,
    CMD_END     = 3'd3,
    CMD_FINISH  = 3'd4
  } srec_cmd_e;

  localparam logic [3:0] REC_HEADER = 4'd0;
  localparam logic [3:0] REC_DATA16 = 4'd1;
  localparam logic [3:0] REC_DATA24 = 4'd2;
  localparam logic [3:0] REC_DATA32 = 4'd3;
  localparam logic [3:0] REC_COUNT  = 4'd5;
  localparam logic [3:0] REC_START32 = 4'd7;
  localparam logic [3:0] REC_START24 = 4'd8;
  localparam logic [3:0] REC_START16 = 4'd9;

  localparam logic [CHAR_W-1:0] CHR_S  = 7'h53;
  localparam logic [CHAR_W-1:0] CHR_LF = 7'h0A;
  localparam logic [CHAR_W-1:0] CHR_NUL = 7'h00;

  typedef enum logic {
    T_IDLE,
    T_EMIT
  } srec_top_state_e;

  typedef enum logic [2:0] {
    E_IDLE,
    E_TYPE,
    E_LEN,
    E_ADDR,
    E_DATA,
    E_SUM,
    E_EOL
  } srec_emit_state_e;

  // One record to emit: type digit, address and its byte count, payload.
  typedef struct packed {
    logic              start;
    logic [3:0]        rtype;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        abytes;
    logic [FILL_W-1:0] dlen;
    logic              hdr_src;
    logic              last;
  } srec_req_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h37 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

// ----- hdl/srec_if.sv -----
// Command and piece channel interfaces of the S-record writer.
interface srec_in_if;
  logic                         valid;
  logic                         ready;
  logic [srec_pkg::CMD_W-1:0]   command;
  logic [srec_pkg::ADDR_W-1:0]  address;
  logic [srec_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, command, address, data_byte, input ready);
  modport sink   (input valid, command, address, data_byte, output ready);
endinterface

interface srec_out_if;
  logic                         valid;
  logic                         ready;
  logic [srec_pkg::CHAR_W-1:0]  first_char;
  logic [srec_pkg::CHAR_W-1:0]  second_char;
  logic [srec_pkg::CCNT_W-1:0]  char_count;
  logic                         last;

  modport source (output valid, first_char, second_char, char_count, last, input ready);
  modport sink   (input valid, first_char, second_char, char_count, last, output ready);
endinterface

// ----- hdl/srec_record_writer.sv -----
// Top level of the S-record writer: command decoding, section state, configuration.
`include "srec_record_writer_defines.svh"

// Motorola S-record writer. Commands arrive on in_ch (begin, section start,
// data byte, section end, finish) and the text leaves on out_ch as pieces of
// one or two ASCII characters: the record tag "S" and its type digit, then
// each byte as two uppercase hex digits, and a single newline piece closing
// each record; last marks the final piece caused by one command. Begin
// writes an S0 header carrying the four header_text bytes. Data bytes are
// held in a 32-entry buffer memory and leave as an S1, S2 or S3 record
// (chosen by the record's start address) when the buffer is full, at
// section end, or when a new section starts; finish drops any pending bytes
// and writes an S5 count record if the data record count fits 16 bits, then
// an S9, S8 or S7 start record if the start address register is nonzero.
// Timing: data bytes that do not fill the buffer are taken back to back. A
// command that writes a record holds off in_ch while it launches the record,
// sends its pieces, one per cycle while out_ch is ready, and hands back; a
// record is 4 + address bytes + data bytes pieces, paced by the single piece
// sequencer and its one-per-cycle buffer read port. A finish that writes
// both records chains the start record once the count record is sequenced.
// A result piece sits in the output register while the next command is
// taken. Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i:
// index 0 start address, index 1 header_text; both read as zero after reset.
module srec_record_writer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  srec_in_if.sink                      in_ch,
  srec_out_if.source                   out_ch,
  input  logic                         cfg_we_i,
  input  logic [srec_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [srec_pkg::CFG_W-1:0]   cfg_wdata_i
);
  import srec_pkg::*;

  srec_top_state_e state_q, state_d;

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [ADDR_W-1:0] cur_addr_q, cur_addr_d;
  logic [ADDR_W-1:0] rec_cnt_q, rec_cnt_d;
  logic              pend_q, pend_d;
  logic [CFG_W-1:0]  entry_q;
  logic [CFG_W-1:0]  header_q;

  srec_req_t         req;
  srec_req_t         entry_req;
  logic              emit_busy;
  logic              accept;
  logic              buf_we;
  logic [FILL_W-1:0] fill_inc;
  logic [3:0]        flush_type;
  logic [2:0]        flush_ab;
  logic [ADDR_W-1:0] rec_cnt_inc;

  assign in_ch.ready = (state_q == T_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign fill_inc    = fill_q + 1'b1;
  assign rec_cnt_inc = (rec_cnt_q != '1) ? rec_cnt_q + 32'd1 : rec_cnt_q;

  // Data record width follows the start address of the record.
  always_comb begin
    priority if (cur_addr_q[31:16] == 16'h0000) begin
      flush_type = REC_DATA16;
      flush_ab   = 3'd2;
    end else if (cur_addr_q[31:24] == 8'h00) begin
      flush_type = REC_DATA24;
      flush_ab   = 3'd3;
    end else begin
      flush_type = REC_DATA32;
      flush_ab   = 3'd4;
    end
  end

  // Start record for the entry point; always closes the finish output.
  always_comb begin
    entry_req         = '0;
    entry_req.start   = 1'b1;
    entry_req.addr    = entry_q;
    entry_req.last    = 1'b1;
    priority if (entry_q[31:16] == 16'h0000) begin
      entry_req.rtype  = REC_START16;
      entry_req.abytes = 3'd2;
    end else if (entry_q[31:24] == 8'h00) begin
      entry_req.rtype  = REC_START24;
      entry_req.abytes = 3'd3;
    end else begin
      entry_req.rtype  = REC_START32;
      entry_req.abytes = 3'd4;
    end
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    cur_addr_d = cur_addr_q;
    rec_cnt_d  = rec_cnt_q;
    pend_d     = pend_q;
    buf_we     = 1'b0;
    req        = '0;
    // Data records share everything but their length.
    req.rtype  = flush_type;
    req.addr   = cur_addr_q;
    req.abytes = flush_ab;
    req.dlen   = fill_q;
    req.last   = 1'b1;
    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          unique case (in_ch.command)
            CMD_BEGIN: begin
              // Drop pending bytes, restart the record count.
              fill_d      = '0;
              rec_cnt_d   = '0;
              req.start   = 1'b1;
              req.rtype   = REC_HEADER;
              req.addr    = '0;
              req.abytes  = 3'd2;
              req.dlen    = FILL_W'(4);
              req.hdr_src = 1'b1;
            end
            CMD_SECTION: begin
              if (fill_q != '0) begin
                req.start = 1'b1;
                rec_cnt_d = rec_cnt_inc;
              end
              fill_d     = '0;
              cur_addr_d = in_ch.address;
            end
            CMD_DATA: begin
              buf_we = 1'b1;
              if (fill_inc >= FILL_W'(MAX_DATA_BYTES)) begin
                req.start  = 1'b1;
                req.dlen   = fill_inc;
                rec_cnt_d  = rec_cnt_inc;
                cur_addr_d = cur_addr_q + ADDR_W'(fill_inc);
                fill_d     = '0;
              end else begin
                fill_d = fill_inc;
              end
            end
            CMD_END: begin
              if (fill_q != '0) begin
                req.start  = 1'b1;
                rec_cnt_d  = rec_cnt_inc;
                cur_addr_d = cur_addr_q + ADDR_W'(fill_q);
              end
              fill_d = '0;
            end
            CMD_FINISH: begin
              fill_d = '0;
              if (rec_cnt_q[31:16] == 16'h0000) begin
                req.start  = 1'b1;
                req.rtype  = REC_COUNT;
                req.addr   = rec_cnt_q;
                req.abytes = 3'd2;
                req.dlen   = '0;
                req.last   = (entry_q == '0);
                pend_d     = (entry_q != '0);
              end else if (entry_q != '0) begin
                req = entry_req;
              end
            end
            default: ;
          endcase
          // The section start flush keeps the old address for its record.
          if (req.start && in_ch.command == CMD_SECTION) begin
            cur_addr_d = in_ch.address;
          end
          if (req.start) state_d = T_EMIT;
        end
      end
      T_EMIT: begin
        // Wait for the record to be sequenced, then chain the start record if one is pending.
        if (!emit_busy) begin
          if (pend_q) begin
            req    = entry_req;
            pend_d = 1'b0;
          end else begin
            state_d = T_IDLE;
          end
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= T_IDLE;
      fill_q     <= '0;
      cur_addr_q <= '0;
      rec_cnt_q  <= '0;
      pend_q     <= 1'b0;
      entry_q    <= '0;
      header_q   <= '0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      cur_addr_q <= cur_addr_d;
      rec_cnt_q  <= rec_cnt_d;
      pend_q     <= pend_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_START_ADDR) begin
          entry_q <= cfg_wdata_i;
        end else begin
          header_q <= cfg_wdata_i;
        end
      end
    end
  end

  srec_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .busy_o      (emit_busy),
    .header_i    (header_q),
    .buf_we_i    (buf_we),
    .buf_waddr_i (fill_q[BUF_AW-1:0]),
    .buf_wdata_i (in_ch.data_byte),
    .out_ch      (out_ch)
  );

  `SREC_ASSERT(a_fill_range, fill_q < FILL_W'(MAX_DATA_BYTES), "buffer fill count past record size")
  `SREC_ASSERT(a_accept_idle, accept |-> !emit_busy, "command taken while a record is in flight")
  `SREC_ASSERT(a_pend_in_emit, pend_q |-> state_q == T_EMIT, "start record pending outside emission")

endmodule

// ----- hdl/srec_emit.sv -----
// Record emitter: data buffer memory, piece sequencer, checksum and output register.
`include "srec_record_writer_defines.svh"

module srec_emit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  srec_pkg::srec_req_t          req_i,
  output logic                         busy_o,
  input  logic [srec_pkg::CFG_W-1:0]   header_i,
  input  logic                         buf_we_i,
  input  logic [srec_pkg::BUF_AW-1:0]  buf_waddr_i,
  input  logic [srec_pkg::BYTE_W-1:0]  buf_wdata_i,
  srec_out_if.source                   out_ch
);
  import srec_pkg::*;

  srec_emit_state_e state_q, state_d;

  logic [BYTE_W-1:0] mem [BUF_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic [BUF_AW-1:0] raddr;

  logic [3:0]        rtype_q;
  logic [2:0]        abytes_q;
  logic [FILL_W-1:0] dlen_q;
  logic              hdr_src_q;
  logic              last_q;
  logic [BYTE_W-1:0] rlen_q;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [FILL_W-1:0] idx_q, idx_d;
  logic [BYTE_W-1:0] sum_q, sum_d;

  logic              out_vld_q;
  logic [CHAR_W-1:0] out_first_q, out_second_q;
  logic [CCNT_W-1:0] out_cnt_q;
  logic              out_last_q;

  logic              load;
  logic              emit;
  logic [BYTE_W-1:0] pbyte;
  logic [BYTE_W-1:0] hdr_byte;
  logic [BYTE_W-1:0] req_rlen;
  logic [ADDR_W-1:0] req_addr_al;
  logic [CHAR_W-1:0] p_first, p_second;
  logic [CCNT_W-1:0] p_cnt;
  logic              p_last;

  assign load   = !out_vld_q || out_ch.ready;
  assign busy_o = (state_q != E_IDLE);
  assign raddr  = idx_d[BUF_AW-1:0];

  assign req_rlen = {5'b00000, req_i.abytes} + BYTE_W'(req_i.dlen) + 8'd1;

  always_comb begin
    unique case (req_i.abytes)
      3'd2:    req_addr_al = {req_i.addr[15:0], 16'h0000};
      3'd3:    req_addr_al = {req_i.addr[23:0], 8'h00};
      default: req_addr_al = req_i.addr;
    endcase
  end

  always_comb begin
    unique case (idx_q[1:0])
      2'd0:    hdr_byte = header_i[31:24];
      2'd1:    hdr_byte = header_i[23:16];
      2'd2:    hdr_byte = header_i[15:8];
      default: hdr_byte = header_i[7:0];
    endcase
  end

  always_comb begin
    state_d  = state_q;
    addr_d   = addr_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    emit     = 1'b0;
    pbyte    = '0;
    p_first  = CHR_NUL;
    p_second = CHR_NUL;
    p_cnt    = 2'd2;
    p_last   = 1'b0;
    unique case (state_q)
      E_IDLE: begin
        if (req_i.start) begin
          state_d = E_TYPE;
          addr_d  = req_addr_al;
          cnt_d   = req_i.abytes;
          idx_d   = '0;
          sum_d   = req_rlen;
        end
      end
      E_TYPE: begin
        emit     = 1'b1;
        p_first  = CHR_S;
        p_second = hex_char(rtype_q);
        if (load) state_d = E_LEN;
      end
      E_LEN: begin
        emit  = 1'b1;
        pbyte = rlen_q;
        if (load) state_d = E_ADDR;
      end
      E_ADDR: begin
        emit  = 1'b1;
        pbyte = addr_q[ADDR_W-1 -: BYTE_W];
        if (load) begin
          addr_d = addr_q << BYTE_W;
          sum_d  = sum_q + pbyte;
          cnt_d  = cnt_q - 3'd1;
          if (cnt_q == 3'd1) begin
            state_d = (dlen_q == '0) ? E_SUM : E_DATA;
          end
        end
      end
      E_DATA: begin
        emit  = 1'b1;
        pbyte = hdr_src_q ? hdr_byte : rdata_q;
        if (load) begin
          sum_d = sum_q + pbyte;
          idx_d = idx_q + 1'b1;
          if (idx_d == dlen_q) state_d = E_SUM;
        end
      end
      E_SUM: begin
        emit  = 1'b1;
        pbyte = ~sum_q;
        if (load) state_d = E_EOL;
      end
      E_EOL: begin
        emit    = 1'b1;
        p_first = CHR_LF;
        p_cnt   = 2'd1;
        p_last  = last_q;
        if (load) state_d = E_IDLE;
      end
      default: state_d = E_IDLE;
    endcase
    if (state_q != E_TYPE && state_q != E_EOL) begin
      p_first  = hex_char(pbyte[7:4]);
      p_second = hex_char(pbyte[3:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= E_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit && load) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Record context and sequencer datapath.
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    sum_q  <= sum_d;
    if (state_q == E_IDLE && req_i.start) begin
      rtype_q   <= req_i.rtype;
      abytes_q  <= req_i.abytes;
      dlen_q    <= req_i.dlen;
      hdr_src_q <= req_i.hdr_src;
      last_q    <= req_i.last;
      rlen_q    <= req_rlen;
    end
    if (emit && load) begin
      out_first_q  <= p_first;
      out_second_q <= p_second;
      out_cnt_q    <= p_cnt;
      out_last_q   <= p_last;
    end
  end

  // Buffer memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (buf_we_i) mem[buf_waddr_i] <= buf_wdata_i;
    rdata_q <= mem[raddr];
  end

  assign out_ch.valid       = out_vld_q;
  assign out_ch.first_char  = out_first_q;
  assign out_ch.second_char = out_second_q;
  assign out_ch.char_count  = out_cnt_q;
  assign out_ch.last        = out_last_q;

  `SREC_ASSERT(a_start_when_idle, req_i.start |-> state_q == E_IDLE, "record start while emitter busy")
  `SREC_ASSERT(a_data_in_range, state_q == E_DATA |-> idx_q < dlen_q && abytes_q != 3'd0, "data index beyond record length")
  `SREC_ASSERT(a_eol_piece, out_vld_q && out_cnt_q == 2'd1 |-> out_first_q == CHR_LF, "single-character piece is not a newline")

endmodule
